>>> rtl/qbf_pkg.sv
// Shared types, constants and the weight table of the quadratic B-spline flattener.
// Used by every module of the block; has no dependencies of its own.
package qbf_pkg;

  // Coordinate and weight widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned WeightW = 10;
  localparam int unsigned StepW   = 4;

  // Steps within one window of three vertices
  localparam logic [StepW-1:0] FirstStep = 4'd0;
  localparam logic [StepW-1:0] LastStep  = 4'd9;

  // Blend arithmetic: weighted sum, magnitude and reciprocal product widths
  localparam int unsigned SumW       = 27;
  localparam int unsigned MagW       = 25;
  localparam int unsigned RecipW     = 26;
  localparam int unsigned ProdW      = MagW + RecipW;
  localparam int unsigned RecipShift = 35;
  localparam int unsigned QuotW      = 16;

  // Division by the weight scale: floor(2^35 / 1000), then one correction
  localparam logic [RecipW-1:0] RecipMul = 26'd34359738;
  localparam int unsigned       Scale    = 1000;
  localparam int unsigned       Round    = 500;

  // One control vertex or point
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } vertex_t;

  // Input item
  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic                     final_vertex;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [CoordW-1:0] step_x;
    logic signed [CoordW-1:0] step_y;
    logic                     is_absolute;
    logic                     run_end;
    logic                     curve_end;
  } out_item_t;

  // Work handed from the front to the back: one or two windows
  typedef struct packed {
    vertex_t a;
    vertex_t b;
    vertex_t c;
    logic    two_windows;     // second window is (b, c, c)
    logic    absolute_start;  // first point goes out as vertex a
    logic    curve_end;       // last point closes the curve
  } job_t;

  // Weight triple over the scale
  typedef struct packed {
    logic [WeightW-1:0] wa;
    logic [WeightW-1:0] wb;
    logic [WeightW-1:0] wc;
  } weights_t;

  // Fixed weights of the uniform quadratic basis, ten steps per window
  function automatic weights_t step_weights(logic [StepW-1:0] step);
    weights_t w;
    case (step)
      4'd0:    w = '{wa: 10'd500, wb: 10'd500, wc: 10'd0};
      4'd1:    w = '{wa: 10'd405, wb: 10'd590, wc: 10'd5};
      4'd2:    w = '{wa: 10'd320, wb: 10'd660, wc: 10'd20};
      4'd3:    w = '{wa: 10'd245, wb: 10'd710, wc: 10'd45};
      4'd4:    w = '{wa: 10'd180, wb: 10'd740, wc: 10'd80};
      4'd5:    w = '{wa: 10'd125, wb: 10'd750, wc: 10'd125};
      4'd6:    w = '{wa: 10'd80,  wb: 10'd740, wc: 10'd180};
      4'd7:    w = '{wa: 10'd45,  wb: 10'd710, wc: 10'd245};
      4'd8:    w = '{wa: 10'd20,  wb: 10'd660, wc: 10'd320};
      4'd9:    w = '{wa: 10'd5,   wb: 10'd590, wc: 10'd405};
      default: w = '{wa: 10'd0,   wb: 10'd0,   wc: 10'd0};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/qbf_front.sv
// Front end: accepts control vertices, tracks the curve and forms window jobs.
// Depends on qbf_pkg.
module qbf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qbf_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output qbf_pkg::job_t     q_job_o
);

  // Progress through the current curve
  typedef enum logic [2:0] {
    SeenNone = 3'b001,
    SeenOne  = 3'b010,
    SeenMany = 3'b100
  } seen_e;

  seen_e             seen_q, seen_d;
  qbf_pkg::vertex_t  older_q, older_d;
  qbf_pkg::vertex_t  newer_q, newer_d;
  qbf_pkg::vertex_t  vtx;
  logic              accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign vtx        = '{x: in_item_i.vertex_x, y: in_item_i.vertex_y};

  // Classify the item and build its job
  always_comb begin
    seen_d   = seen_q;
    older_d  = older_q;
    newer_d  = newer_q;
    q_push_o = 1'b0;
    q_job_o  = '{a: older_q, b: newer_q, c: vtx, two_windows: in_item_i.final_vertex,
                 absolute_start: (seen_q == SeenOne), curve_end: in_item_i.final_vertex};
    if (accept) begin
      case (seen_q)
        SeenNone: begin
          // start of a curve: vertex doubled as front padding
          older_d = vtx;
          newer_d = vtx;
          if (in_item_i.final_vertex) begin
            q_push_o = 1'b1;
            q_job_o  = '{a: vtx, b: vtx, c: vtx, two_windows: 1'b0,
                         absolute_start: 1'b1, curve_end: 1'b1};
          end else begin
            seen_d = SeenOne;
          end
        end
        SeenOne, SeenMany: begin
          q_push_o = 1'b1;
          older_d  = newer_q;
          newer_d  = vtx;
          seen_d   = in_item_i.final_vertex ? SeenNone : SeenMany;
        end
        default: seen_d = SeenNone;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= SeenNone;
    end else begin
      seen_q <= seen_d;
    end
  end

  // Held vertices; always written before read within a curve
  always_ff @(posedge clk_i) begin
    older_q <= older_d;
    newer_q <= newer_d;
  end

endmodule

>>> rtl/qbf_queue.sv
// Short job queue between front and back end.
// Depends on qbf_pkg for the job type.
module qbf_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qbf_pkg::job_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  output qbf_pkg::job_t data_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  qbf_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

>>> rtl/qbf_back.sv
// Back end: steps through each window and computes the curve points in a pipeline.
// Sequencer, weighted sum, reciprocal multiply, rounding fix-up, delta output register.
// Depends on qbf_pkg.
module qbf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  qbf_pkg::job_t      q_job_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qbf_pkg::out_item_t out_item_o
);

  localparam int unsigned SumW  = qbf_pkg::SumW;
  localparam int unsigned MagW  = qbf_pkg::MagW;
  localparam int unsigned ProdW = qbf_pkg::ProdW;
  localparam int unsigned CW    = qbf_pkg::CoordW;

  // Per-point side information carried down the pipeline
  typedef struct packed {
    qbf_pkg::vertex_t first;
    logic             absolute;
    logic             run_end;
    logic             curve_end;
  } tag_t;

  // Divide stage data for one coordinate
  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic [MagW-1:0]  mag;
    logic             neg;
  } div_t;

  logic                       en;
  // sequencer
  logic                       job_vld_q;
  qbf_pkg::job_t              job_q;
  logic [qbf_pkg::StepW-1:0]  step_q;
  logic                       win_q;
  logic                       last_issue;
  qbf_pkg::vertex_t           op_a, op_b, op_c;
  qbf_pkg::weights_t          w;
  tag_t                       issue_tag;
  logic signed [SumW-1:0]     sum_x, sum_y;
  // pipeline
  logic                       a_vld_q, b_vld_q, c_vld_q, out_vld_q;
  logic signed [SumW-1:0]     a_sum_x_q, a_sum_y_q;
  tag_t                       a_tag_q, b_tag_q, c_tag_q;
  div_t                       b_div_x_q, b_div_y_q;
  qbf_pkg::vertex_t           c_pt_q;
  qbf_pkg::vertex_t           prev_q;
  qbf_pkg::out_item_t         out_item_q;

  // Weighted term, extended to the sum width
  function automatic logic signed [SumW-1:0] weigh(
    logic [qbf_pkg::WeightW-1:0] wt,
    logic signed [CW-1:0]        v
  );
    logic signed [SumW-1:0] ws;
    logic signed [SumW-1:0] vs;
    ws = $signed({{(SumW - qbf_pkg::WeightW){1'b0}}, wt});
    vs = {{(SumW - CW){v[CW-1]}}, v};
    return ws * vs;
  endfunction

  // Magnitude and reciprocal product
  function automatic div_t start_div(logic signed [SumW-1:0] s);
    div_t                   d;
    logic signed [SumW-1:0] m;
    m      = s[SumW-1] ? -s : s;
    d.neg  = s[SumW-1];
    d.mag  = MagW'(m);
    d.prod = ProdW'(d.mag) * ProdW'(qbf_pkg::RecipMul);
    return d;
  endfunction

  // Quotient fix-up and sign, truncating toward zero
  function automatic logic signed [CW-1:0] finish_div(div_t d);
    logic [qbf_pkg::QuotW-1:0] qe;
    logic [qbf_pkg::QuotW-1:0] q;
    logic [MagW-1:0]           rem;
    qe  = d.prod[qbf_pkg::RecipShift +: qbf_pkg::QuotW];
    rem = d.mag - MagW'(MagW'(qe) * MagW'(qbf_pkg::Scale));
    q   = (rem >= MagW'(qbf_pkg::Scale)) ? qe + 1'b1 : qe;
    return d.neg ? $signed(-q) : $signed(q);
  endfunction

  // Whole pipeline holds while the output register is full and stalled
  assign en = !(out_vld_q && out_stall_i);

  // Sequencer: one step per cycle unless the pipeline holds, ten per window, one or two windows per job
  assign last_issue = job_vld_q && (step_q == qbf_pkg::LastStep) &&
                      (win_q || !job_q.two_windows);
  assign q_pop_o    = en && q_valid_i && (!job_vld_q || last_issue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      step_q    <= qbf_pkg::FirstStep;
      win_q     <= 1'b0;
    end else if (en) begin
      if (q_pop_o) begin
        job_vld_q <= 1'b1;
        step_q    <= qbf_pkg::FirstStep;
        win_q     <= 1'b0;
      end else if (last_issue) begin
        job_vld_q <= 1'b0;
      end else if (job_vld_q) begin
        if (step_q == qbf_pkg::LastStep) begin
          step_q <= qbf_pkg::FirstStep;
          win_q  <= 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) job_q <= q_job_i;
  end

  // Window operands; the second window uses the vertex as its own end padding
  always_comb begin
    op_a = win_q ? job_q.b : job_q.a;
    op_b = win_q ? job_q.c : job_q.b;
    op_c = job_q.c;
    w    = qbf_pkg::step_weights(step_q);
    issue_tag = '{first: job_q.a,
                  absolute: job_q.absolute_start && !win_q && (step_q == qbf_pkg::FirstStep),
                  run_end: last_issue,
                  curve_end: last_issue && job_q.curve_end};
    sum_x = weigh(w.wa, op_a.x) + weigh(w.wb, op_b.x) + weigh(w.wc, op_c.x)
            + SumW'(qbf_pkg::Round);
    sum_y = weigh(w.wa, op_a.y) + weigh(w.wb, op_b.y) + weigh(w.wc, op_c.y)
            + SumW'(qbf_pkg::Round);
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      prev_q    <= '0;
    end else if (en) begin
      a_vld_q   <= job_vld_q;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      out_vld_q <= c_vld_q;
      if (c_vld_q) prev_q <= c_pt_q;
    end
  end

  // Stage data: sums, reciprocal products, points, result item
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_sum_x_q <= sum_x;
      a_sum_y_q <= sum_y;
      a_tag_q   <= issue_tag;
      b_div_x_q <= start_div(a_sum_x_q);
      b_div_y_q <= start_div(a_sum_y_q);
      b_tag_q   <= a_tag_q;
      c_pt_q    <= '{x: finish_div(b_div_x_q), y: finish_div(b_div_y_q)};
      c_tag_q   <= b_tag_q;
      out_item_q.step_x      <= c_tag_q.absolute ? c_tag_q.first.x : c_pt_q.x - prev_q.x;
      out_item_q.step_y      <= c_tag_q.absolute ? c_tag_q.first.y : c_pt_q.y - prev_q.y;
      out_item_q.is_absolute <= c_tag_q.absolute;
      out_item_q.run_end     <= c_tag_q.run_end;
      out_item_q.curve_end   <= c_tag_q.curve_end;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

>>> rtl/quadratic_bspline_flattener.sv
// Top level of the quadratic B-spline flattener: front end, job queue, back end.
// Depends on qbf_pkg, qbf_front, qbf_queue and qbf_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one control vertex
//   per item; final_vertex marks the last vertex of a curve. Output channel
//   (out_valid_o / out_stall_i / out_item_o) gives curve points as 16-bit deltas,
//   the first point of each curve as the absolute first vertex.
//   A vertex other than the first of a curve gives ten points; the final vertex of
//   a longer curve gives twenty; a lone final vertex gives ten; the first vertex of
//   a longer curve gives none.
//   Throughput: one point per cycle from the back end's step sequencer while the
//   output is not stalled. The front end takes a vertex whenever the queue has
//   room, independently of the back end.
//   After its vertex is taken, the first point of a window passes the queue, the
//   sequencer load, the sum, multiply and fix-up stages and the output register.
//   Reset: queue empty, no curve in progress, output channel idle.
//   Output stall: the output register holds its item and the point pipeline
//   freezes; the queue keeps taking vertices until it is full.
module quadratic_bspline_flattener #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qbf_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qbf_pkg::out_item_t out_item_o
);

  logic          q_full, q_push, q_valid, q_pop;
  qbf_pkg::job_t q_job_in, q_job_out;

  // Vertex intake and classification
  qbf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_job_in)
  );

  // Decoupling queue
  qbf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_job_in),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_job_out),
    .pop_i       (q_pop)
  );

  // Point generation
  qbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (q_job_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> rtl/qbf_checker.sv
// Port-level checks of the quadratic B-spline flattener, bound to the top level.
// Depends on qbf_pkg.
module qbf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input qbf_pkg::out_item_t out_item_o
);

  logic out_take;
  logic in_curve_q, in_curve_d;

  assign out_take = out_valid_o && !out_stall_i;

  // Tracks whether a curve has started on the output and not yet ended
  always_comb begin
    in_curve_d = in_curve_q;
    if (out_take && out_item_o.is_absolute) in_curve_d = 1'b1;
    if (out_take && out_item_o.curve_end)   in_curve_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_curve_q <= 1'b0;
    end else begin
      in_curve_q <= in_curve_d;
    end
  end

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // The curve's last point also ends its run
  a_curve_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.curve_end |-> out_item_o.run_end)
    else $error("curve end without run end");

  // An absolute point opens a window and never closes a run
  a_abs_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_absolute |-> !out_item_o.run_end)
    else $error("absolute point marked as run end");

  // A new absolute point only after the previous curve has ended
  a_abs_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && out_item_o.is_absolute |-> !in_curve_q)
    else $error("absolute point inside an open curve");

  // Non-absolute points only inside an open curve
  a_delta_in_curve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !out_item_o.is_absolute |-> in_curve_q)
    else $error("delta point outside a curve");

endmodule

bind quadratic_bspline_flattener qbf_checker u_qbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
